// ===== hw/rtl/dpds_pkg.sv =====
`default_nettype none
package dpds_pkg;

   localparam int PAGES   = 8;
   localparam int COLUMNS = 128;
   localparam int DEPTH   = PAGES * COLUMNS;
   localparam int ADDR_W  = $clog2(DEPTH);

   localparam int PAGE_W  = 3;
   localparam int COL_W   = 7;
   localparam int BYTE_W  = 8;

   typedef logic [PAGE_W-1:0] page_type;
   typedef logic [COL_W-1:0]  col_type;
   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [ADDR_W-1:0] addr_type;

   typedef struct packed {
      page_type page;
      col_type  first;
      col_type  last;
   } span_type;

   function automatic logic in_range(input page_type page, input col_type col);
      return (int'(page) < PAGES) && (int'(col) < COLUMNS);
   endfunction

   function automatic addr_type shadow_addr(input page_type page, input col_type col);
      return ADDR_W'(int'(page) * COLUMNS + int'(col));
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/dpds_ram.sv =====
`default_nettype none
module dpds_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]         wr_data,
   input  wire                      rd_en,
   input  wire  [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/display_page_dirty_span_finder.sv =====
// A span is registered onto rsp_ from the compare stage holding the beat that closes it;
// that beat is registered into that stage from req_ together with its shadow read.
// Throughput: one beat per cycle while req_stall is low; the single shadow RAM is read and
// written once per beat. A held rsp_ beat holds the beat under compare, and req_stall
// stays high until it drains. Reset: synchronous; afterwards the shadow RAM is zeroed one
// entry per cycle over PAGES*COLUMNS (1024) entries, with req_stall high until all are clear.
`default_nettype none
module display_page_dirty_span_finder (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [2:0]  req_page_index,
   input  wire  [6:0]  req_column_index,
   input  wire  [7:0]  req_pixel_byte,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [2:0]  rsp_span_page,
   output logic [6:0]  rsp_span_first,
   output logic [6:0]  rsp_span_last
);

   logic               clearing_ff;
   dpds_pkg::addr_type clr_addr_ff;

   logic               s1_valid_ff, s1_valid_in;
   dpds_pkg::page_type s1_page_ff;
   dpds_pkg::col_type  s1_col_ff;
   dpds_pkg::byte_type s1_byte_ff;

   logic               fwd_valid_ff;
   dpds_pkg::addr_type fwd_addr_ff;
   dpds_pkg::byte_type fwd_byte_ff;

   logic               run_open_ff, run_open_in;
   dpds_pkg::span_type run_ff, run_in;

   logic               rsp_valid_ff, rsp_valid_in;
   dpds_pkg::span_type rsp_ff, rsp_in;

   logic               accept;
   logic               s1_fire;
   logic               s1_in_range;
   dpds_pkg::addr_type s1_addr;
   dpds_pkg::byte_type rd_data;
   dpds_pkg::byte_type old_byte;
   logic               differs;
   logic               contiguous;
   logic               emit;
   logic               ram_wr_en;
   dpds_pkg::addr_type ram_wr_addr;
   dpds_pkg::byte_type ram_wr_data;

   assign s1_fire   = s1_valid_ff && !(rsp_valid_ff && rsp_stall);
   assign req_stall = clearing_ff || (s1_valid_ff && !s1_fire);
   assign accept    = req_valid && !req_stall;

   assign s1_in_range = dpds_pkg::in_range(s1_page_ff, s1_col_ff);
   assign s1_addr     = dpds_pkg::shadow_addr(s1_page_ff, s1_col_ff);

   assign ram_wr_en   = clearing_ff || (s1_fire && s1_in_range);
   assign ram_wr_addr = clearing_ff ? clr_addr_ff : s1_addr;
   assign ram_wr_data = clearing_ff ? '0 : s1_byte_ff;

   dpds_ram #(
      .WIDTH (dpds_pkg::BYTE_W),
      .DEPTH (dpds_pkg::DEPTH)
   ) u_shadow (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (accept),
      .rd_addr (dpds_pkg::shadow_addr(req_page_index, req_column_index)),
      .rd_data (rd_data)
   );

   assign old_byte = (fwd_valid_ff && fwd_addr_ff == s1_addr) ? fwd_byte_ff : rd_data;
   assign differs  = s1_in_range && (old_byte != s1_byte_ff);
   assign contiguous = run_open_ff && (run_ff.page == s1_page_ff) &&
                       ({1'b0, run_ff.last} + 8'd1 == {1'b0, s1_col_ff});

   always_comb begin
      run_open_in = run_open_ff;
      run_in      = run_ff;
      emit        = 1'b0;
      rsp_in      = run_ff;
      if (!differs) begin
         emit        = run_open_ff;
         run_open_in = 1'b0;
      end else begin
         if (run_open_ff && !contiguous) begin
            emit = 1'b1;
         end
         if (contiguous) begin
            run_in.last = s1_col_ff;
         end else begin
            run_in.page  = s1_page_ff;
            run_in.first = s1_col_ff;
            run_in.last  = s1_col_ff;
         end
         run_open_in = 1'b1;
         if (int'(s1_col_ff) == dpds_pkg::COLUMNS - 1 && !emit) begin
            emit        = 1'b1;
            rsp_in      = run_in;
            run_open_in = 1'b0;
         end
      end
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_fire && emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         run_open_ff  <= 1'b0;
         run_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (int'(clr_addr_ff) == dpds_pkg::DEPTH - 1) begin
               clearing_ff <= 1'b0;
            end
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (s1_fire) begin
            run_open_ff <= run_open_in;
            run_ff      <= run_in;
            if (s1_in_range) begin
               fwd_valid_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_page_ff <= req_page_index;
         s1_col_ff  <= req_column_index;
         s1_byte_ff <= req_pixel_byte;
      end
      if (s1_fire && s1_in_range) begin
         fwd_addr_ff <= s1_addr;
         fwd_byte_ff <= s1_byte_ff;
      end
      if (s1_fire && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_span_page  = rsp_ff.page;
   assign rsp_span_first = rsp_ff.first;
   assign rsp_span_last  = rsp_ff.last;

endmodule
`default_nettype wire
